>>> hdl/rlqg_pkg.sv
package rlqg_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int BASE_W = 12;
  localparam int FAR_W = 24;
  localparam int SAT_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_CNT_W = $clog2(COORD_WIDTH);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  localparam logic [1:0] SIDE_TOP = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CHUNK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT = CFG_IDX_W'(1);

  localparam logic [BASE_W-1:0] BASE_CHUNK_RST = BASE_W'(1280);
  localparam logic [FAR_W-1:0] FAR_LIMIT_RST = FAR_W'(5120000);

  typedef struct packed {
    logic       cfg_we;
    logic       start_load;
    logic       div_step;
    logic       snap_commit;
    logic       step_begin;
    logic       emit_quad;
    logic       emit_done;
    logic       slot_adv;
    logic       tile_load;
    logic       outer_add;
    logic [1:0] side;
  } ctrl_cmd_t;

  typedef struct packed {
    logic running;
    logic at_limit;
    logic slot_wrap;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/rlqg_ctrl.sv
module rlqg_ctrl
  import rlqg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SNAP  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_ADV   = 3'd4;
  localparam logic [2:0] ST_TILE  = 3'd5;
  localparam logic [2:0] ST_OUTER = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [1:0]           side_q, side_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 idle;

  assign idle        = (state_q == ST_IDLE);
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.side   = side_q;
    cmd_o.cfg_we = cfg_valid_i && idle;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_START: begin
              cmd_o.start_load = 1'b1;
              cnt_d   = '0;
              state_d = ST_DIV;
            end
            OP_STEP: begin
              if (stat_i.running && !stat_i.at_limit) begin
                cmd_o.step_begin = 1'b1;
                side_d  = SIDE_TOP;
                state_d = ST_EMIT;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_ABORT: state_d = ST_DONE;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(COORD_WIDTH - 1)) begin
          state_d = ST_SNAP;
        end
      end
      ST_SNAP: begin
        cmd_o.snap_commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_quad = 1'b1;
          side_d = side_q + 2'd1;
          if (side_q == SIDE_LEFT) begin
            state_d = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        cmd_o.slot_adv = 1'b1;
        state_d = stat_i.slot_wrap ? ST_TILE : ST_IDLE;
      end
      ST_TILE: begin
        cmd_o.tile_load = 1'b1;
        state_d = ST_OUTER;
      end
      ST_OUTER: begin
        cmd_o.outer_add = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= SIDE_TOP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hdl/rlqg_datapath.sv
module rlqg_datapath
  import rlqg_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctrl_cmd_t                     cmd_i,
  output dp_stat_t                      stat_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0] cam_x_i,
  input  logic signed [COORD_WIDTH-1:0] cam_z_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [COORD_WIDTH-1:0] quad_x_o,
  output logic signed [COORD_WIDTH-1:0] quad_z_o,
  output logic [SAT_W-1:0]              quad_size_o,
  output logic [1:0]                    side_o,
  output logic [SAT_W-1:0]              slot_count_o,
  output logic                          last_o,
  output logic                          done_res_o
);

  localparam int KW     = $clog2(COUNT_WIDTH);
  localparam int GrowW  = 5 + FRAC_BITS + COUNT_WIDTH;
  localparam int CmpW   = (GrowW > COORD_WIDTH) ? GrowW : COORD_WIDTH;
  localparam int TileW  = BASE_W + COUNT_WIDTH;
  localparam int WideW  = (TileW > COORD_WIDTH) ? TileW : COORD_WIDTH;
  localparam logic [CmpW-1:0] GrowRadius = CmpW'(20) << FRAC_BITS;
  localparam logic [SAT_W-1:0] SatMax = '1;

  function automatic logic [BASE_W-1:0] rem_step(input logic [BASE_W-1:0] rem,
                                                 input logic              bit_in,
                                                 input logic [BASE_W-1:0] div);
    logic [BASE_W:0] trial;
    logic [BASE_W:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, div};
    if (trial >= {1'b0, div}) begin
      rem_step = diff[BASE_W-1:0];
    end else begin
      rem_step = trial[BASE_W-1:0];
    end
  endfunction

  logic [BASE_W-1:0]      base_q;
  logic [FAR_W-1:0]       far_q;
  logic                   running_q;
  logic [SAT_W-1:0]       emitted_q;
  logic                   out_valid_q;

  logic [COORD_WIDTH-1:0] center_x_q, center_z_q;
  logic                   neg_x_q, neg_z_q;
  logic [COORD_WIDTH-1:0] mag_x_q, mag_z_q;
  logic [BASE_W-1:0]      rem_x_q, rem_z_q;
  logic [COORD_WIDTH-1:0] inner_q, outer_q, tile_q, off_q;
  logic [KW-1:0]          k_q;
  logic [COUNT_WIDTH-1:0] slots_q, idx_q;

  logic [COORD_WIDTH-1:0] quad_x_q, quad_z_q;
  logic [SAT_W-1:0]       quad_size_q, slot_count_q;
  logic [1:0]             side_q;
  logic                   last_q, done_q;

  logic [COUNT_WIDTH-1:0] nslots, idx_inc, slots_half, slots_next;
  logic                   wrap, grow;
  logic [CmpW-1:0]        inner_w, grow_thr;
  logic [WideW-1:0]       tile_wide;
  logic [COORD_WIDTH-1:0] rx, rz, qx, qz;
  logic [SAT_W-1:0]       size_sat;

  assign nslots  = (slots_q < COUNT_WIDTH'(2)) ? COUNT_WIDTH'(1) : slots_q - COUNT_WIDTH'(1);
  assign idx_inc = idx_q + COUNT_WIDTH'(1);
  assign wrap    = (idx_inc >= nslots) || (idx_inc == '0);

  assign inner_w  = CmpW'(inner_q);
  assign grow_thr = GrowRadius << k_q;
  assign grow     = (inner_w > GrowRadius) && (slots_q[5:0] == 6'd0) &&
                    (grow_thr < inner_w) && (k_q < KW'(COUNT_WIDTH - 1));
  assign slots_half = grow ? (slots_q >> 1) : slots_q;
  assign slots_next = slots_half + COUNT_WIDTH'(2);
  assign tile_wide  = WideW'(base_q) << k_q;

  assign rx = (base_q == '0) ? '0 : COORD_WIDTH'(rem_x_q);
  assign rz = (base_q == '0) ? '0 : COORD_WIDTH'(rem_z_q);

  always_comb begin
    unique case (cmd_i.side)
      SIDE_TOP: begin
        qx = center_x_q - outer_q + off_q;
        qz = center_z_q - outer_q;
      end
      SIDE_RIGHT: begin
        qx = center_x_q + inner_q;
        qz = center_z_q - outer_q + off_q;
      end
      SIDE_BOTTOM: begin
        qx = center_x_q + inner_q - off_q;
        qz = center_z_q + inner_q;
      end
      SIDE_LEFT: begin
        qx = center_x_q - outer_q;
        qz = center_z_q + inner_q - off_q;
      end
    endcase
  end

  assign size_sat = (tile_q > COORD_WIDTH'(SatMax)) ? SatMax : tile_q[SAT_W-1:0];

  assign stat_o.running   = running_q;
  assign stat_o.at_limit  = inner_q >= COORD_WIDTH'(far_q);
  assign stat_o.slot_wrap = wrap;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_CHUNK_RST;
      far_q       <= FAR_LIMIT_RST;
      running_q   <= 1'b0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        if (cfg_index_i == CFG_BASE_CHUNK) begin
          base_q <= cfg_data_i[BASE_W-1:0];
        end else if (cfg_index_i == CFG_FAR_LIMIT) begin
          far_q <= cfg_data_i[FAR_W-1:0];
        end
      end
      if (cmd_i.snap_commit) begin
        running_q <= 1'b1;
        emitted_q <= '0;
      end
      if (cmd_i.emit_done) begin
        running_q <= 1'b0;
      end
      if (cmd_i.step_begin && emitted_q != SatMax) begin
        emitted_q <= emitted_q + SAT_W'(1);
      end
      if (cmd_i.emit_quad || cmd_i.emit_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_load) begin
      center_x_q <= cam_x_i;
      center_z_q <= cam_z_i;
      neg_x_q    <= cam_x_i[COORD_WIDTH-1];
      neg_z_q    <= cam_z_i[COORD_WIDTH-1];
      mag_x_q    <= cam_x_i[COORD_WIDTH-1] ? -cam_x_i : cam_x_i;
      mag_z_q    <= cam_z_i[COORD_WIDTH-1] ? -cam_z_i : cam_z_i;
      rem_x_q    <= '0;
      rem_z_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_x_q <= rem_step(rem_x_q, mag_x_q[COORD_WIDTH-1], base_q);
      rem_z_q <= rem_step(rem_z_q, mag_z_q[COORD_WIDTH-1], base_q);
      mag_x_q <= mag_x_q << 1;
      mag_z_q <= mag_z_q << 1;
    end
    if (cmd_i.snap_commit) begin
      center_x_q <= neg_x_q ? center_x_q + rx : center_x_q - rx;
      center_z_q <= neg_z_q ? center_z_q + rz : center_z_q - rz;
      inner_q    <= '0;
      outer_q    <= COORD_WIDTH'(base_q);
      tile_q     <= COORD_WIDTH'(base_q);
      off_q      <= '0;
      k_q        <= '0;
      slots_q    <= COUNT_WIDTH'(2);
      idx_q      <= '0;
    end
    if (cmd_i.slot_adv) begin
      if (wrap) begin
        idx_q   <= '0;
        off_q   <= '0;
        slots_q <= slots_next;
        k_q     <= grow ? k_q + KW'(1) : k_q;
        inner_q <= outer_q;
      end else begin
        idx_q <= idx_inc;
        off_q <= off_q + tile_q;
      end
    end
    if (cmd_i.tile_load) begin
      tile_q <= tile_wide[COORD_WIDTH-1:0];
    end
    if (cmd_i.outer_add) begin
      outer_q <= outer_q + tile_q;
    end
    if (cmd_i.emit_quad) begin
      quad_x_q     <= qx;
      quad_z_q     <= qz;
      quad_size_q  <= size_sat;
      side_q       <= cmd_i.side;
      slot_count_q <= emitted_q;
      last_q       <= (cmd_i.side == SIDE_LEFT);
      done_q       <= 1'b0;
    end else if (cmd_i.emit_done) begin
      quad_x_q     <= '0;
      quad_z_q     <= '0;
      quad_size_q  <= '0;
      side_q       <= SIDE_TOP;
      slot_count_q <= emitted_q;
      last_q       <= 1'b1;
      done_q       <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quad_x_o     = signed'(quad_x_q);
  assign quad_z_o     = signed'(quad_z_q);
  assign quad_size_o  = quad_size_q;
  assign side_o       = side_q;
  assign slot_count_o = slot_count_q;
  assign last_o       = last_q;
  assign done_res_o   = done_q;

endmodule

>>> hdl/ring_lod_quad_generator_unit.sv
// Start: taken from idle, then a bit-serial remainder (x and z lanes
//   in parallel) and a commit step; the next item is taken after the commit.
// Step: four quads from the output register, back to back unless the output
//   stalls, then a slot advance, plus tile and outer updates at a ring wrap.
// Abort, or a step at the far limit or while not running: one done transfer.
// Reset clears the controller, run flag, slot count and config to defaults.
module ring_lod_quad_generator_unit
  import rlqg_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic signed [COORD_WIDTH-1:0] cam_x_i,
  input  logic signed [COORD_WIDTH-1:0] cam_z_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] quad_x_o,
  output logic signed [COORD_WIDTH-1:0] quad_z_o,
  output logic [SAT_W-1:0]              quad_size_o,
  output logic [1:0]                    side_o,
  output logic [SAT_W-1:0]              slot_count_o,
  output logic                          last_o,
  output logic                          done_res_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rlqg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rlqg_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cam_x_i      (cam_x_i),
    .cam_z_i      (cam_z_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .quad_x_o     (quad_x_o),
    .quad_z_o     (quad_z_o),
    .quad_size_o  (quad_size_o),
    .side_o       (side_o),
    .slot_count_o (slot_count_o),
    .last_o       (last_o),
    .done_res_o   (done_res_o)
  );

endmodule
